// ===== rtl/bfh_pkg.sv =====
`default_nettype none
package bfh_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int NUM_SYMBOLS   = 256;

  // Field widths of the request and result channels
  localparam int FUNC_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int POS_W      = 8;
  localparam int COUNT_W    = 16;
  localparam int SYMBOL_W   = 8;
  localparam int DISTINCT_W = 9;
  localparam int BITS_W     = 27;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD       = 2'd0,
    FUNC_COUNT     = 2'd1,
    FUNC_NTH       = 2'd2,
    FUNC_CLEAR     = 2'd3
  } func_t;

endpackage
`default_nettype wire

// ===== rtl/bfh_req_if.sv =====
`default_nettype none
interface bfh_req_if;
  import bfh_pkg::*;

  logic                valid;
  logic                ready;
  func_t               func;
  logic [BYTE_W-1:0]   byte_value;
  logic [POS_W-1:0]    position;

  modport source (output valid, func, byte_value, position, input ready);
  modport sink   (input valid, func, byte_value, position, output ready);
endinterface
`default_nettype wire

// ===== rtl/bfh_rsp_if.sv =====
`default_nettype none
interface bfh_rsp_if;
  import bfh_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COUNT_W-1:0]    symbol_count;
  logic [SYMBOL_W-1:0]   distinct_symbol;
  logic                  position_valid;
  logic [DISTINCT_W-1:0] distinct_total;
  logic [BITS_W-1:0]     total_bits;

  modport source (output valid, symbol_count, distinct_symbol, position_valid,
                  distinct_total, total_bits, input ready);
  modport sink   (input valid, symbol_count, distinct_symbol, position_valid,
                  distinct_total, total_bits, output ready);
endinterface
`default_nettype wire

// ===== rtl/byte_frequency_histogram.sv =====
// Byte histogram with a first-appearance list of distinct symbols. Requests
// add a byte, read the count of a symbol, read the n-th distinct symbol, or
// clear everything; each request gives exactly one result. Each request has
// a registered read of the count memory and the order memory, then an update
// that writes back and loads the result register once that register is free.
// A new request is taken the cycle after the write back, also while the last
// result still waits to be taken. Counts sit in a memory whose entries carry
// a seen flag in flip-flops, so reset and clear take effect at once with no
// clearing pass. Counts and the message length saturate at their maximum.
`default_nettype none
module byte_frequency_histogram #(
  parameter int ALPHABET    = 256,
  parameter int COUNT_BITS  = 16,
  parameter int LENGTH_BITS = 24
) (
  input  wire logic  clk,
  input  wire logic  rst,
  bfh_req_if.sink    req,
  bfh_rsp_if.source  rsp
);
  import bfh_pkg::*;

  localparam int SYM_W = $clog2(ALPHABET);

  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_t;

  state_t                  state;
  func_t                   func_r;
  logic [BYTE_W-1:0]       sym_r;
  logic [POS_W-1:0]        pos_r;
  logic [ALPHABET-1:0]     seen;
  logic [DISTINCT_W-1:0]   distinct;
  logic [LENGTH_BITS-1:0]  length;

  logic                    out_valid;
  logic [COUNT_W-1:0]      out_count;
  logic [SYMBOL_W-1:0]     out_symbol;
  logic                    out_pos_valid;
  logic [DISTINCT_W-1:0]   out_distinct;
  logic [BITS_W-1:0]       out_bits;

  logic                    req_fire;
  logic                    calc_fire;
  logic [SYM_W-1:0]        sym_addr;
  logic                    sym_ok;
  logic                    pos_ok;
  logic                    room;
  logic [COUNT_BITS-1:0]   cnt_rdata;
  logic [COUNT_BITS-1:0]   cur_cnt;
  logic [COUNT_BITS-1:0]   inc_cnt;
  logic [SYMBOL_W-1:0]     ord_rdata;
  logic                    cnt_we;
  logic                    ord_we;
  logic [LENGTH_BITS-1:0]  length_next;
  logic [DISTINCT_W-1:0]   distinct_next;
  logic [COUNT_BITS-1:0]   cnt_result;
  logic [63:0]             cnt_wide;
  logic [63:0]             bits_wide;

  assign req_fire  = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign calc_fire = (state == S_CALC) && (!out_valid || rsp.ready);

  assign sym_addr = sym_r[SYM_W-1:0];
  assign sym_ok   = 32'(sym_r) < ALPHABET;
  assign pos_ok   = ({1'b0, pos_r} < distinct) && (32'(pos_r) < ALPHABET);
  assign room     = distinct < DISTINCT_W'(ALPHABET);

  // An entry never seen since the last clear reads as zero
  assign cur_cnt  = seen[sym_addr] ? cnt_rdata : '0;
  assign inc_cnt  = (cur_cnt == '1) ? cur_cnt : cur_cnt + COUNT_BITS'(1);

  assign cnt_we = calc_fire && (func_r == FUNC_ADD) && sym_ok;
  assign ord_we = cnt_we && !seen[sym_addr] && room;

  always_comb begin
    length_next   = length;
    distinct_next = distinct;
    cnt_result    = '0;
    case (func_r)
      FUNC_ADD: begin
        if (length != '1) begin
          length_next = length + LENGTH_BITS'(1);
        end
        if (ord_we) begin
          distinct_next = distinct + DISTINCT_W'(1);
        end
        if (sym_ok) begin
          cnt_result = inc_cnt;
        end
      end
      FUNC_COUNT: begin
        if (sym_ok) begin
          cnt_result = cur_cnt;
        end
      end
      FUNC_NTH: begin
      end
      FUNC_CLEAR: begin
        length_next   = '0;
        distinct_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign cnt_wide  = 64'(cnt_result);
  assign bits_wide = 64'({length_next, 3'b000});

  bfh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (ALPHABET)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (cnt_we),
    .wr_addr (sym_addr),
    .wr_data (inc_cnt),
    .rd_en   (req_fire),
    .rd_addr (req.byte_value[SYM_W-1:0]),
    .rd_data (cnt_rdata)
  );

  bfh_ram #(
    .WIDTH (SYMBOL_W),
    .DEPTH (ALPHABET)
  ) u_order_ram (
    .clk     (clk),
    .wr_en   (ord_we),
    .wr_addr (distinct[SYM_W-1:0]),
    .wr_data (sym_r),
    .rd_en   (req_fire),
    .rd_addr (req.position[SYM_W-1:0]),
    .rd_data (ord_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      seen      <= '0;
      distinct  <= '0;
      length    <= '0;
    end else begin
      if (rsp.ready && !calc_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            func_r <= req.func;
            sym_r  <= req.byte_value;
            pos_r  <= req.position;
            state  <= S_CALC;
          end
        end
        S_CALC: begin
          // Hold until the result register is free
          if (calc_fire) begin
            if (func_r == FUNC_CLEAR) begin
              seen <= '0;
            end else if (cnt_we) begin
              seen[sym_addr] <= 1'b1;
            end
            distinct      <= distinct_next;
            length        <= length_next;
            out_valid     <= 1'b1;
            out_count     <= cnt_wide[COUNT_W-1:0];
            out_pos_valid <= (func_r == FUNC_NTH) && pos_ok;
            out_symbol    <= ((func_r == FUNC_NTH) && pos_ok) ? ord_rdata : '0;
            out_distinct  <= distinct_next;
            out_bits      <= bits_wide[BITS_W-1:0];
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.symbol_count    = out_count;
  assign rsp.distinct_symbol = out_symbol;
  assign rsp.position_valid  = out_pos_valid;
  assign rsp.distinct_total  = out_distinct;
  assign rsp.total_bits      = out_bits;

  a_distinct_matches_seen: assert property (@(posedge clk) disable iff (rst)
    $countones(seen) == int'(distinct))
    else $error("distinct count differs from number of seen symbols");

  a_distinct_bound: assert property (@(posedge clk) disable iff (rst)
    int'(distinct) <= ALPHABET)
    else $error("distinct count beyond alphabet");

  a_stall_holds_calc: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC) && out_valid && !rsp.ready |=> (state == S_CALC) && out_valid)
    else $error("pending result overwritten");

endmodule
`default_nettype wire

// ===== rtl/bfh_ram.sv =====
`default_nettype none
module bfh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
